// File: sv/memory_range_table_sort_merge_check_assert.svh
// Assertion macros shared by the range table checker.
`ifndef MEMORY_RANGE_TABLE_SORT_MERGE_CHECK_ASSERT_SVH
`define MEMORY_RANGE_TABLE_SORT_MERGE_CHECK_ASSERT_SVH
// Assert that an antecedent implies a consequent on the next clock.
`define MRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
// Assert that an expression holds at every clock.
`define MRT_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`endif

// File: sv/mrtsm_pkg.sv
// Package with commands and sequencer states of the range table.
package mrtsm_pkg;
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RDI,
    ST_SORT_RDJ,
    ST_SORT_CMP,
    ST_SORT_WRJ,
    ST_MRG_RD,
    ST_MRG_CMP,
    ST_MRG_WR,
    ST_QRY_RD,
    ST_QRY_CMP,
    ST_DONE
  } state_e;

  localparam int unsigned StartW = 64;
  localparam int unsigned PagesW = 52;
endpackage

// File: sv/memory_range_table_sort_merge_check.sv
// Range table with load, exchange sort plus merge, and address lookup.
// One command is taken while busy_o is low; its single result appears with
// done_o for one cycle and there is no back-pressure: the receiver cannot
// stall it. Clear and load go straight to ST_DONE. A query reads one held
// entry per ST_QRY_RD and ST_QRY_CMP pair. A build runs the exchange sort
// through the single memory read port, ST_SORT_RDJ and ST_SORT_CMP per
// compare plus ST_SORT_WRJ per swap, then the merge pass with ST_MRG_RD and
// ST_MRG_CMP per entry. The one-port-read table memory sets these steps.
module memory_range_table_sort_merge_check #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] range_start_i,
  input  logic [51:0] range_pages_i,
  input  logic [63:0] query_address_i,
  output logic        address_valid_o,
  output logic [6:0]  entries_held_o,
  output logic        status_o
);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  mrtsm_pkg::state_e state_q, state_d;

  // table memory: start and pages in one word
  logic [115:0] mem [MAX_ENTRIES];
  logic [115:0] rdata_q;
  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic [115:0] wdata;
  logic         re;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, w_q, w_d;
  logic [63:0]   a_s_q, a_s_d, qa_q, qa_d;
  logic [51:0]   a_p_q, a_p_d;
  logic [1:0]    cmd_q, cmd_d;
  logic          hit_q, hit_d, st_q, st_d, done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrtsm_pkg::ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      cmd_q   <= mrtsm_pkg::CMD_CLEAR;
      hit_q   <= 1'b0;
      st_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      cmd_q   <= cmd_d;
      hit_q   <= hit_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; w_q <= w_d;
    a_s_q <= a_s_d; a_p_q <= a_p_d; qa_q <= qa_d;
  end

  logic [63:0] r_s, a_end, r_end;
  logic [51:0] r_p;
  assign r_s   = rdata_q[115:52];
  assign r_p   = rdata_q[51:0];
  assign a_end = a_s_q + {a_p_q, 12'h000};
  assign r_end = r_s + {r_p, 12'h000};

  // sequence commands over the memory
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; w_d = w_q;
    a_s_d = a_s_q; a_p_d = a_p_q; qa_d = qa_q; cmd_d = cmd_q;
    hit_d = hit_q; st_d = st_q; done_d = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
    unique case (state_q)
      mrtsm_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_d = command_i; qa_d = query_address_i;
          hit_d = 1'b0; st_d = 1'b0; i_d = '0;
          state_d = mrtsm_pkg::ST_DONE;
          unique case (mrtsm_pkg::cmd_e'(command_i))
            mrtsm_pkg::CMD_CLEAR: cnt_d = '0;
            mrtsm_pkg::CMD_LOAD: begin
              if (cnt_q < CW'(MAX_ENTRIES)) begin
                we = 1'b1; waddr = cnt_q[AW-1:0];
                wdata = {range_start_i, range_pages_i};
                cnt_d = cnt_q + 1'b1;
              end else st_d = 1'b1;
            end
            mrtsm_pkg::CMD_BUILD: if (cnt_q > CW'(1)) state_d = mrtsm_pkg::ST_SORT_RDI;
            mrtsm_pkg::CMD_QUERY: if (cnt_q != '0) state_d = mrtsm_pkg::ST_QRY_RD;
            default: ;
          endcase
        end
      end
      // load slot i as the running minimum
      mrtsm_pkg::ST_SORT_RDI: begin
        re = 1'b1; raddr = i_q[AW-1:0]; j_d = i_q + 1'b1;
        state_d = mrtsm_pkg::ST_SORT_RDJ;
      end
      mrtsm_pkg::ST_SORT_RDJ: begin
        if (j_q == i_q + 1'b1) begin
          a_s_d = r_s; a_p_d = r_p;
        end
        if (j_q >= cnt_q) begin
          // finish slot i
          i_d = i_q + 1'b1;
          if (i_q + 1'b1 >= cnt_q - 1'b1) begin
            i_d = '0; w_d = '0;
            state_d = mrtsm_pkg::ST_MRG_RD;
          end else state_d = mrtsm_pkg::ST_SORT_RDI;
        end else begin
          re = 1'b1; raddr = j_q[AW-1:0];
          state_d = mrtsm_pkg::ST_SORT_CMP;
        end
      end
      // swap when slot j is strictly below slot i: write slot j's word to slot i
      mrtsm_pkg::ST_SORT_CMP: begin
        if (a_s_q > r_s) begin
          we = 1'b1; waddr = i_q[AW-1:0]; wdata = rdata_q;
          state_d = mrtsm_pkg::ST_SORT_WRJ;
        end else begin
          j_d = j_q + 1'b1;
          state_d = mrtsm_pkg::ST_SORT_RDJ;
        end
      end
      mrtsm_pkg::ST_SORT_WRJ: begin
        we = 1'b1; waddr = j_q[AW-1:0];
        wdata = {a_s_q, a_p_q};
        // slot j's old word, still in the read register, becomes the minimum
        a_s_d = r_s; a_p_d = r_p;
        j_d = j_q + 1'b1;
        state_d = mrtsm_pkg::ST_SORT_RDJ;
      end
      // merge walk: i reads, w writes
      mrtsm_pkg::ST_MRG_RD: begin
        if (i_q >= cnt_q) begin
          we = 1'b1; waddr = w_q[AW-1:0]; wdata = {a_s_q, a_p_q};
          cnt_d = w_q + 1'b1;
          state_d = mrtsm_pkg::ST_DONE;
        end else begin
          re = 1'b1; raddr = i_q[AW-1:0];
          state_d = mrtsm_pkg::ST_MRG_CMP;
        end
      end
      mrtsm_pkg::ST_MRG_CMP: begin
        i_d = i_q + 1'b1;
        state_d = mrtsm_pkg::ST_MRG_RD;
        if (i_q == '0) begin
          a_s_d = r_s; a_p_d = r_p;
        end else if (a_end == r_s) begin
          a_p_d = a_p_q + r_p;
        end else begin
          we = 1'b1; waddr = w_q[AW-1:0]; wdata = {a_s_q, a_p_q};
          w_d = w_q + 1'b1;
          a_s_d = r_s; a_p_d = r_p;
        end
      end
      mrtsm_pkg::ST_QRY_RD: begin
        re = 1'b1; raddr = i_q[AW-1:0];
        state_d = mrtsm_pkg::ST_QRY_CMP;
      end
      mrtsm_pkg::ST_QRY_CMP: begin
        if (qa_q >= r_s && qa_q < r_end) hit_d = 1'b1;
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 >= cnt_q) state_d = mrtsm_pkg::ST_DONE;
        else state_d = mrtsm_pkg::ST_QRY_RD;
      end
      mrtsm_pkg::ST_DONE: begin
        done_d = 1'b1;
        state_d = mrtsm_pkg::ST_IDLE;
      end
      default: state_d = mrtsm_pkg::ST_IDLE;
    endcase
  end

  assign busy_o          = (state_q != mrtsm_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign address_valid_o = hit_q & (cmd_q == mrtsm_pkg::CMD_QUERY);
  assign entries_held_o  = 7'(cnt_q);
  assign status_o        = st_q & (cmd_q == mrtsm_pkg::CMD_LOAD);
endmodule

// File: sv/mrtsm_checker.sv
// Port checker for the range table, bound to the top level.
`include "memory_range_table_sort_merge_check_assert.svh"
module mrtsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [1:0] command_i,
  input logic       address_valid_o,
  input logic [6:0] entries_held_o,
  input logic       status_o
);
  `MRT_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  `MRT_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `MRT_ASSERT_NEXT(a_clear_zero, clk_i, rst_ni,
    start_i && !busy_o && command_i == mrtsm_pkg::CMD_CLEAR, busy_o && entries_held_o == 7'd0)
  `MRT_ASSERT_ALWAYS(a_flags_excl, clk_i, rst_ni, !(address_valid_o && status_o))
endmodule

bind memory_range_table_sort_merge_check mrtsm_checker u_mrtsm_checker (.*);

// File: dv/tb_memory_range_table_sort_merge_check.sv
// Testbench for the range table: directed rows, then random load/build/query episodes.
module tb_memory_range_table_sort_merge_check;

  localparam int unsigned Depth = 64;

  typedef struct packed {
    logic       address_valid;
    logic [6:0] entries_held;
    logic       status;
  } range_result_t;

  typedef struct {
    mrtsm_pkg::cmd_e cmd;
    logic [63:0]     start;
    logic [51:0]     pages;
    logic [63:0]     addr;
    bit              typed;
    range_result_t   res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  command_i = mrtsm_pkg::CMD_CLEAR;
  logic [63:0] range_start_i = '0;
  logic [51:0] range_pages_i = '0;
  logic [63:0] query_address_i = '0;
  logic        address_valid_o;
  logic [6:0]  entries_held_o;
  logic        status_o;

  // Predictor copy of the table
  logic [63:0]   tbl_start [Depth];
  logic [51:0]   tbl_pages [Depth];
  int unsigned   tbl_count;
  range_result_t pending_results[$];
  int unsigned   error_count;
  int unsigned   idle_pct;

  memory_range_table_sort_merge_check #(.MAX_ENTRIES(Depth)) i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [63:0] span_of(input logic [51:0] p);
    return {p, 12'h000};
  endfunction

  // Apply one command to the predictor table and return its result
  function automatic range_result_t predict_range(input mrtsm_pkg::cmd_e cmd,
                                                  input logic [63:0] s,
                                                  input logic [51:0] p, input logic [63:0] a);
    range_result_t r;
    logic [63:0] ts, run_s;
    logic [51:0] tp, run_p;
    int unsigned rd, wr, nx;
    r = '0;
    case (cmd)
      mrtsm_pkg::CMD_CLEAR: tbl_count = 0;
      mrtsm_pkg::CMD_LOAD: begin
        if (tbl_count < Depth) begin
          tbl_start[tbl_count] = s;
          tbl_pages[tbl_count] = p;
          tbl_count++;
        end else begin
          r.status = 1'b1;
        end
      end
      mrtsm_pkg::CMD_BUILD: begin
        // Exchange sort by start address
        for (int i = 0; i < tbl_count; i++) begin
          for (int j = i + 1; j < tbl_count; j++) begin
            if (tbl_start[i] > tbl_start[j]) begin
              ts = tbl_start[i]; tp = tbl_pages[i];
              tbl_start[i] = tbl_start[j]; tbl_pages[i] = tbl_pages[j];
              tbl_start[j] = ts; tbl_pages[j] = tp;
            end
          end
        end
        // Join neighbours whose running end meets the next start
        rd = 0;
        wr = 0;
        while (rd < tbl_count) begin
          run_s = tbl_start[rd];
          run_p = tbl_pages[rd];
          nx = rd + 1;
          while (nx < tbl_count && run_s + span_of(run_p) == tbl_start[nx]) begin
            run_p = run_p + tbl_pages[nx];
            nx++;
          end
          tbl_start[wr] = run_s;
          tbl_pages[wr] = run_p;
          wr++;
          rd = nx;
        end
        tbl_count = wr;
      end
      default: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (a >= tbl_start[i] && a < tbl_start[i] + span_of(tbl_pages[i])) r.address_valid = 1'b1;
        end
      end
    endcase
    r.entries_held = tbl_count[6:0];
    return r;
  endfunction

  // Drive one item, wait for acceptance, queue its expected result
  task automatic send_item(input mrtsm_pkg::cmd_e cmd, input logic [63:0] s,
                           input logic [51:0] p,
                           input logic [63:0] a, input bit typed = 0,
                           input range_result_t typed_res = '0);
    range_result_t r;
    command_i       <= cmd;
    range_start_i   <= s;
    range_pages_i   <= p;
    query_address_i <= a;
    start_i         <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    r = predict_range(cmd, s, p, a);
    pending_results.push_back(typed ? typed_res : r);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [51:0] rand_pages();
    case ($urandom_range(9))
      0: return 52'({$urandom, $urandom});
      1: return '0;
      default: return 52'($urandom_range(1, 16));
    endcase
  endfunction

  // Pick an address near a held range, or anywhere
  function automatic logic [63:0] pick_query();
    int unsigned k;
    logic [63:0] sp;
    if (tbl_count == 0 || $urandom_range(4) == 0) return rand64();
    k = $urandom_range(tbl_count - 1);
    sp = span_of(tbl_pages[k]);
    case ($urandom_range(3))
      0: return tbl_start[k];
      1: return tbl_start[k] + sp;
      2: return tbl_start[k] - 64'd1;
      default: return tbl_start[k] + (sp == 0 ? 64'd0 : rand64() % sp);
    endcase
  endfunction

  // Compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    range_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = pending_results.pop_front();
        if (address_valid_o !== want.address_valid)
          report_mismatch($sformatf("address_valid %b want %b", address_valid_o,
                                    want.address_valid));
        if (entries_held_o !== want.entries_held)
          report_mismatch($sformatf("entries_held %0d want %0d", entries_held_o,
                                    want.entries_held));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %b want %b", status_o, want.status));
      end
    end
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    int unsigned sent, k;
    int unsigned phase_pct[4] = '{0, 73, 0, 25};
    logic [63:0] base, addr;
    logic [51:0] pg;
    logic [63:0] seg_s[$];
    logic [51:0] seg_p[$];
    error_count = 0;
    idle_pct = 0;
    tbl_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: typed results where obvious, predictor elsewhere
    rows.push_back('{mrtsm_pkg::CMD_QUERY, '0, '0, '0, 1, '{1'b0, 7'd0, 1'b0}});
    rows.push_back('{mrtsm_pkg::CMD_BUILD, '0, '0, '0, 1, '{1'b0, 7'd0, 1'b0}});
    rows.push_back('{mrtsm_pkg::CMD_LOAD, '1, '1, '0, 1, '{1'b0, 7'd1, 1'b0}});
    rows.push_back('{mrtsm_pkg::CMD_QUERY, '0, '0, '1, 1, '{1'b0, 7'd1, 1'b0}});
    rows.push_back('{mrtsm_pkg::CMD_BUILD, '0, '0, '0, 1, '{1'b0, 7'd1, 1'b0}});
    rows.push_back('{mrtsm_pkg::CMD_CLEAR, '1, '1, '1, 1, '{1'b0, 7'd0, 1'b0}});
    rows.push_back('{mrtsm_pkg::CMD_LOAD, 64'h3000, 52'd0, '0, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_LOAD, 64'h3000, 52'd2, '0, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_LOAD, 64'h1000, 52'd2, '0, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_LOAD, 64'h0, 52'd1, '0, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_QUERY, '0, '0, 64'h3000, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_QUERY, '0, '0, 64'h4fff, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_BUILD, '0, '0, '0, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_QUERY, '0, '0, 64'h4fff, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_QUERY, '0, '0, 64'h5000, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_LOAD, 64'hffff_ffff_ffff_f000, 52'h0_0000_0000_0001, '0, 0,
                     '0});
    rows.push_back('{mrtsm_pkg::CMD_LOAD, 64'h0, '1, '0, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_BUILD, '0, '0, '0, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_QUERY, '0, '0, 64'hffff_ffff_ffff_ffff, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_QUERY, '0, '0, 64'h0, 0, '0});
    rows.push_back('{mrtsm_pkg::CMD_CLEAR, '0, '0, '0, 1, '{1'b0, 7'd0, 1'b0}});
    foreach (rows[i]) send_item(rows[i].cmd, rows[i].start, rows[i].pages, rows[i].addr,
                                rows[i].typed, rows[i].res);

    // Random episodes: clear, loads, build, queries
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      sent = 0;
      while (sent < 200) begin
        if ($urandom_range(3) != 0) begin
          send_item(mrtsm_pkg::CMD_CLEAR, rand64(), rand_pages(), rand64());
          sent++;
        end
        k = ($urandom_range(29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        // Mostly chains of touching ranges, loaded in shuffled order
        base = ($urandom_range(3) == 0) ? rand64() : {rand64() >> 20, 12'h000};
        seg_s.delete();
        seg_p.delete();
        for (int i = 0; i < k; i++) begin
          pg = rand_pages();
          if ($urandom_range(4) == 0) begin
            seg_s.push_back(rand64());
          end else begin
            seg_s.push_back(base);
            base = base + span_of(pg);
          end
          seg_p.push_back(pg);
        end
        for (int i = k - 1; i > 0; i--) begin
          int unsigned j;
          j = $urandom_range(i);
          {seg_s[i], seg_s[j]} = {seg_s[j], seg_s[i]};
          {seg_p[i], seg_p[j]} = {seg_p[j], seg_p[i]};
        end
        for (int i = 0; i < k; i++) begin
          send_item(mrtsm_pkg::CMD_LOAD, seg_s[i], seg_p[i], rand64());
        end
        sent += k;
        repeat ($urandom_range(1, 3)) begin
          addr = pick_query();
          send_item(mrtsm_pkg::CMD_QUERY, rand64(), rand_pages(), addr);
          sent++;
        end
        if ($urandom_range(4) != 0) begin
          send_item(mrtsm_pkg::CMD_BUILD, rand64(), rand_pages(), rand64());
          sent++;
        end
        repeat ($urandom_range(2, 6)) begin
          addr = pick_query();
          send_item(mrtsm_pkg::CMD_QUERY, rand64(), rand_pages(), addr);
          sent++;
        end
        // Occasional noise: any command with any fields
        if ($urandom_range(5) == 0) begin
          send_item(mrtsm_pkg::cmd_e'($urandom_range(3)), rand64(), rand_pages(), rand64());
          sent++;
        end
      end
      // Hold off until the block has drained
      start_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
